// ===== rtl/core/djk_pkg.sv =====
// Shared types, constants and the pin decode function of the joystick key decoder.
`timescale 1ns / 1ps
`default_nettype none

package djk_pkg;

  localparam int unsigned NumKeys   = 5;
  localparam int unsigned KeyIdxW   = 3;
  localparam int unsigned QuietW    = 16;
  localparam logic [15:0] QuietInit = 16'd2;

  // Beat kind carried in the slave-side tuser
  typedef enum logic [0:0] {
    REQ_EDGE = 1'b0,
    REQ_TICK = 1'b1
  } djk_req_e;

  // One decode handed from front to back: keys that flipped and the new key set
  typedef struct packed {
    logic [NumKeys-1:0] changed;
    logic [NumKeys-1:0] keys;
  } djk_entry_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } djk_q_status_t;

  // Direction pattern to two key indices, one per nibble; 15 means no key
  function automatic logic [7:0] dir_code(input logic [3:0] dir);
    logic [7:0] code;
    unique case (dir)
      4'd0:    code = 8'hff;
      4'd1:    code = 8'h14;
      4'd2:    code = 8'h12;
      4'd3:    code = 8'hf3;
      4'd4:    code = 8'h34;
      4'd5:    code = 8'hff;
      4'd6:    code = 8'hf4;
      4'd7:    code = 8'h34;
      4'd8:    code = 8'h23;
      4'd9:    code = 8'hf2;
      4'd10:   code = 8'hff;
      4'd11:   code = 8'h23;
      4'd12:   code = 8'hf1;
      4'd13:   code = 8'h12;
      4'd14:   code = 8'h14;
      default: code = 8'hf0;
    endcase
    return code;
  endfunction

  // Key index to one-hot key bit; indices past the last key drop out
  function automatic logic [NumKeys-1:0] key_bit(input logic [3:0] idx);
    logic [NumKeys-1:0] bits;
    bits = '0;
    if (idx < 4'(NumKeys)) begin
      bits[idx[KeyIdxW-1:0]] = 1'b1;
    end
    return bits;
  endfunction

  // Pin levels to key set; enter high releases everything
  function automatic logic [NumKeys-1:0] decode_pins(input logic [3:0] dir,
                                                     input logic       enter);
    logic [7:0] code;
    code = dir_code(dir);
    if (enter) begin
      return '0;
    end
    return key_bit(code[3:0]) | key_bit(code[7:4]);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/djk_front.sv =====
// Front end: accepts edge and tick beats, runs the quiet countdown and decodes key changes.
`timescale 1ns / 1ps
`default_nettype none

module djk_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [djk_pkg::QuietW-1:0]          cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                in_kind_i,
  input  wire logic [3:0]                          in_dir_i,
  input  wire logic                                in_enter_i,
  input  wire djk_pkg::djk_q_status_t              q_status_i,
  output logic                                     push_o,
  output djk_pkg::djk_entry_t                      push_data_o
);

  logic [djk_pkg::QuietW-1:0]  quiet_ticks_q;
  logic [djk_pkg::QuietW-1:0]  quiet_cnt_q, quiet_cnt_d, cnt_dec;
  logic                        pending_q, pending_d;
  logic [djk_pkg::NumKeys-1:0] held_q, held_d, new_keys, changed;
  logic                        accept, decode;

  // Take a beat whenever the queue can absorb a decode
  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;

  assign cnt_dec  = (quiet_cnt_q != '0) ? quiet_cnt_q - djk_pkg::QuietW'(1) : quiet_cnt_q;
  assign new_keys = djk_pkg::decode_pins(in_dir_i, in_enter_i);
  assign changed  = held_q ^ new_keys;
  assign decode   = accept && (djk_pkg::djk_req_e'(in_kind_i) == djk_pkg::REQ_TICK) &&
                    (cnt_dec == '0) && pending_q;

  // Advance countdown, pending flag and held keys
  always_comb begin
    quiet_cnt_d = quiet_cnt_q;
    pending_d   = pending_q;
    held_d      = held_q;
    if (accept) begin
      case (djk_pkg::djk_req_e'(in_kind_i))
        djk_pkg::REQ_EDGE: begin
          quiet_cnt_d = quiet_ticks_q;
          pending_d   = 1'b1;
        end
        default: begin
          quiet_cnt_d = cnt_dec;
          if (decode) begin
            pending_d = 1'b0;
            held_d    = new_keys;
          end
        end
      endcase
    end
  end

  // Hand a decode to the back only when some key flipped
  assign push_o              = decode && (changed != '0);
  assign push_data_o.changed = changed;
  assign push_data_o.keys    = new_keys;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_ticks_q <= djk_pkg::QuietInit;
      quiet_cnt_q   <= '0;
      pending_q     <= 1'b1;
      held_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        quiet_ticks_q <= cfg_wdata_i;
      end
      quiet_cnt_q <= quiet_cnt_d;
      pending_q   <= pending_d;
      held_q      <= held_d;
    end
  end

  // Held set never carries more than two keys
  a_held_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(held_q) <= 2)
    else $error("held key set has more than two keys");

  // A push never lands on a full queue
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_status_i.full)
    else $error("push into full queue");

  // A decode leaves nothing pending afterwards
  a_decode_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    decode |=> !pending_q)
    else $error("decode left pending flag set");

endmodule

`default_nettype wire

// ===== rtl/core/djk_queue.sv =====
// Short queue of key-change decodes between front and back.
`timescale 1ns / 1ps
`default_nettype none

module djk_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire djk_pkg::djk_entry_t    push_data_i,
  input  wire logic                   pop_i,
  output djk_pkg::djk_entry_t         head_o,
  output djk_pkg::djk_q_status_t      status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  djk_pkg::djk_entry_t mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                do_push, do_pop;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count past depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("push into full queue");

endmodule

`default_nettype wire

// ===== rtl/core/djk_back.sv =====
// Back end: walks each decode's changed keys and emits one event beat per key.
`timescale 1ns / 1ps
`default_nettype none

module djk_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire djk_pkg::djk_entry_t           head_i,
  input  wire djk_pkg::djk_q_status_t        q_status_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [djk_pkg::KeyIdxW-1:0]        out_key_o,
  output logic                               out_pressed_o,
  output logic                               out_last_o
);

  logic [djk_pkg::NumKeys-1:0] rem_q, rem_d, keys_q, keys_d;
  logic [djk_pkg::NumKeys-1:0] low_bit, rem_left, rem_after;
  logic [djk_pkg::KeyIdxW-1:0] low_idx;
  logic                        load;
  logic                        valid_q, valid_d;
  logic [djk_pkg::KeyIdxW-1:0] key_q;
  logic                        pressed_q, last_q;

  // Pick the lowest remaining changed key
  assign low_bit  = rem_q & (~rem_q + djk_pkg::NumKeys'(1));
  assign rem_left = rem_q & ~low_bit;

  always_comb begin
    low_idx = '0;
    for (int i = djk_pkg::NumKeys - 1; i >= 0; i--) begin
      if (rem_q[i]) begin
        low_idx = djk_pkg::KeyIdxW'(i);
      end
    end
  end

  // Fill the output register when empty or being drained
  assign load      = (rem_q != '0) && (!valid_q || out_ready_i);
  assign rem_after = load ? rem_left : rem_q;

  // Refill from the queue once this decode is walked out
  assign pop_o   = !q_status_i.empty && (rem_after == '0);
  assign rem_d   = pop_o ? head_i.changed : rem_after;
  assign keys_d  = pop_o ? head_i.keys : keys_q;
  assign valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      rem_q   <= rem_d;
      valid_q <= valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    keys_q <= keys_d;
    if (load) begin
      key_q     <= low_idx;
      pressed_q <= |(low_bit & keys_q);
      last_q    <= (rem_left == '0);
    end
  end

  assign out_valid_o   = valid_q;
  assign out_key_o     = key_q;
  assign out_pressed_o = pressed_q;
  assign out_last_o    = last_q;

  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> key_q < djk_pkg::KeyIdxW'(djk_pkg::NumKeys))
    else $error("key index out of range");

  a_load_clears_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !pop_o) |=> (rem_q == $past(rem_left)))
    else $error("emitted key not cleared");

  a_pop_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (rem_q == '0 || (load && rem_left == '0)))
    else $error("queue popped mid decode");

endmodule

`default_nettype wire

// ===== rtl/core/debounced_joystick_key_decoder_unit.sv =====
// Top level of the debounced joystick key decoder.
`timescale 1ns / 1ps
`default_nettype none

// Takes pin-edge and tick beats and emits one press or release beat per changed key,
// lowest key first, with tlast on the final beat a tick causes. An input beat is taken
// every cycle while the decode queue (QueueDepth entries) has room; edges, counting
// ticks and decodes that change nothing produce no output. A decode that changes n keys
// (n from 1 to 4) yields n beats, one per cycle from the output register unless
// m_axis_tready is low; the sustained rate is thus set by the back end's key walk:
// at most one event beat per cycle. Decodes pass queue and walk register before output.
// quiet_ticks resets to 2; a value of 0 behaves like 1.
module debounced_joystick_key_decoder_unit #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,   // quiet_ticks
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [3:0] dir_lines, [4] enter_line, [7:5] zero
  input  wire logic        s_axis_tuser,  // [0] req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [2:0] key_index, [3] pressed, [7:4] zero
  output logic             m_axis_tlast   // last
);

  djk_pkg::djk_entry_t    push_data, head;
  djk_pkg::djk_q_status_t q_status;
  logic                   push, pop;
  logic [2:0]             key_idx;
  logic                   pressed;

  djk_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_kind_i   (s_axis_tuser),
    .in_dir_i    (s_axis_tdata[3:0]),
    .in_enter_i  (s_axis_tdata[4]),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  djk_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  djk_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_key_o     (key_idx),
    .out_pressed_o (pressed),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, pressed, key_idx};

endmodule

`default_nettype wire

// ===== test/debounced_joystick_key_decoder_unit_tb.sv =====
// Testbench for the debounced joystick key decoder: scoreboard-checked random and directed beats.
`timescale 1ns / 1ps

module debounced_joystick_key_decoder_unit_tb;

  localparam int unsigned StallLimit = 4000;  // cycles with no beat and no write
  localparam int unsigned DrainHold  = 16;    // cycles past the last event before a write

  // One expected key event
  typedef struct packed {
    logic [2:0] key;
    logic       pressed;
    logic       last;
  } key_event_t;

  // Tracks held keys and the quiet countdown; holds the key events still due
  class key_event_scoreboard;
    logic [15:0] quiet_ticks;
    logic [4:0]  held;
    logic [15:0] countdown;
    bit          pending;
    logic [7:0]  pin_map [16];
    key_event_t  events_q [$];
    int          mismatches;
    int          beats;
    int          events_seen;
    int          key_decodes;

    function new();
      pin_map = '{8'hff, 8'h14, 8'h12, 8'hf3, 8'h34, 8'hff, 8'hf4, 8'h34,
                  8'h23, 8'hf2, 8'hff, 8'h23, 8'hf1, 8'h12, 8'h14, 8'hf0};
      quiet_ticks = 16'd2;
      held        = '0;
      countdown   = '0;
      pending     = 1'b1;
      mismatches  = 0;
      beats       = 0;
      events_seen = 0;
      key_decodes = 0;
    endfunction

    function void set_quiet(logic [15:0] value);
      quiet_ticks = value;
    endfunction

    function int outstanding();
      return events_q.size();
    endfunction

    // Ticks after an edge until the sample; zero behaves like one
    function int ticks_to_sample();
      return (quiet_ticks == 16'd0) ? 1 : int'(quiet_ticks);
    endfunction

    // Map pin levels to the key set; nibble values past the last key mean no key
    function logic [4:0] pin_keys(logic [3:0] dir, logic enter);
      logic [7:0] code;
      logic [4:0] keys;
      code = pin_map[dir];
      keys = '0;
      if (enter) begin
        return keys;
      end
      if (code[3:0] < 4'd5) keys[code[3:0]] = 1'b1;
      if (code[7:4] < 4'd5) keys[code[7:4]] = 1'b1;
      return keys;
    endfunction

    // Advance the debounce state for one accepted beat and queue its key events
    function void note_input(djk_pkg::djk_req_e req, logic [3:0] dir, logic enter);
      logic [4:0] fresh;
      logic [4:0] flips;
      key_event_t ev;
      int top;
      beats++;
      if (req == djk_pkg::REQ_EDGE) begin
        countdown = quiet_ticks;
        pending   = 1'b1;
        return;
      end
      if (countdown != 16'd0) countdown = countdown - 16'd1;
      if (countdown != 16'd0 || !pending) return;
      pending = 1'b0;
      fresh   = pin_keys(dir, enter);
      flips   = held ^ fresh;
      held    = fresh;
      top     = -1;
      for (int i = 0; i < 5; i++) begin
        if (flips[i]) top = i;
      end
      if (top >= 0) key_decodes++;
      for (int i = 0; i < 5; i++) begin
        if (flips[i]) begin
          ev.key     = 3'(i);
          ev.pressed = fresh[i];
          ev.last    = (i == top);
          events_q.push_back(ev);
        end
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH: %s", msg);
    endfunction

    // Compare one output beat with the oldest expected event
    function void check_result(logic [7:0] data, logic last);
      key_event_t want;
      events_seen++;
      if (events_q.size() == 0) begin
        flag($sformatf("unexpected event key=%0d pressed=%0b last=%0b data=%h",
                       data[2:0], data[3], last, data));
        return;
      end
      want = events_q.pop_front();
      if (data[2:0] !== want.key || data[3] !== want.pressed || data[7:4] !== 4'd0 ||
          last !== want.last) begin
        flag($sformatf({"expected key=%0d pressed=%0b last=%0b, ",
                        "got key=%0d pressed=%0b last=%0b pad=%h"},
                       want.key, want.pressed, want.last, data[2:0], data[3], last,
                       data[7:4]));
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [15:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;  // [3:0] dir_lines, [4] enter_line, [7:5] zero
  logic        s_axis_tuser  = 1'b0;  // [0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;  // [2:0] key_index, [3] pressed, [7:4] zero
  logic        m_axis_tlast;

  key_event_scoreboard sb = new();

  int src_idle_pct  = 0;
  int sink_stall_pct = 0;
  int quiet_used [$];
  int idle_cycles = 0;

  debounced_joystick_key_decoder_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Check each output beat, then pick the next ready level
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tlast);
    end
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("watchdog: no progress for %0d cycles", idle_cycles);
        $display("[debounced_joystick_key_decoder_unit] ERROR");
        $finish;
      end
    end
  end

  // Drive one input beat, with random gaps before it, and hold it until taken
  task automatic send_beat(djk_pkg::djk_req_e req, logic [3:0] dir, logic enter);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {3'b000, enter, dir};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(req, dir, enter);
  endtask

  function automatic logic rand_enter();
    return ($urandom_range(3) == 0);
  endfunction

  // Edge, counting ticks, then the tick whose pins get sampled
  task automatic press_pattern(logic [3:0] dir, logic enter);
    int n;
    n = sb.ticks_to_sample();
    send_beat(djk_pkg::REQ_EDGE, 4'($urandom_range(15)), 1'($urandom_range(1)));
    repeat (n - 1) begin
      send_beat(djk_pkg::REQ_TICK, 4'($urandom_range(15)), 1'($urandom_range(1)));
    end
    send_beat(djk_pkg::REQ_TICK, dir, enter);
  endtask

  // Stop sending and wait until every expected event is out, plus a hold-off
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DrainHold) @(posedge clk_i);
  endtask

  task automatic write_quiet(logic [15:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.set_quiet(value);
    cfg_we_i <= 1'b0;
    quiet_used.push_back(int'(value));
  endtask

  // Mostly clean debounce sequences, some retriggered ones, some loose beats
  task automatic random_phase(int src_pct, int sink_pct, logic [15:0] quiet, int beats_wanted);
    int start;
    int pick;
    int partial;
    write_quiet(quiet);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    start = sb.beats;
    while (sb.beats - start < beats_wanted) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        press_pattern(4'($urandom_range(15)), rand_enter());
      end else if (pick < 85) begin
        partial = $urandom_range(sb.ticks_to_sample() - 1);
        send_beat(djk_pkg::REQ_EDGE, 4'($urandom_range(15)), 1'($urandom_range(1)));
        repeat (partial) begin
          send_beat(djk_pkg::REQ_TICK, 4'($urandom_range(15)), 1'($urandom_range(1)));
        end
      end else begin
        send_beat(djk_pkg::djk_req_e'($urandom_range(1)), 4'($urandom_range(15)),
                  1'($urandom_range(1)));
      end
      // hold the sender mid-phase until the output side is empty
      if (sb.beats - start >= beats_wanted / 2 && sb.beats - start < beats_wanted / 2 + 4) begin
        drain();
      end
    end
  endtask

  initial begin
    int unsigned r;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: first tick decodes straight from reset
    send_beat(djk_pkg::REQ_TICK, 4'd15, 1'b0);
    press_pattern(4'd0, 1'b0);
    press_pattern(4'd1, 1'b0);
    press_pattern(4'd8, 1'b0);
    // enter high releases both held keys
    press_pattern(4'd8, 1'b1);
    // tick with nothing pending
    send_beat(djk_pkg::REQ_TICK, 4'd0, 1'b1);
    // retrigger the countdown before it runs out
    send_beat(djk_pkg::REQ_EDGE, 4'd15, 1'b1);
    send_beat(djk_pkg::REQ_TICK, 4'd0, 1'b0);
    send_beat(djk_pkg::REQ_EDGE, 4'd0, 1'b0);
    send_beat(djk_pkg::REQ_TICK, 4'd15, 1'b1);
    send_beat(djk_pkg::REQ_TICK, 4'd2, 1'b0);
    // sample that matches the held set
    press_pattern(4'd2, 1'b0);
    send_beat(djk_pkg::REQ_TICK, 4'd5, 1'b0);

    // Zero quiet time samples on the first tick
    write_quiet(16'd0);
    press_pattern(4'd15, 1'b0);
    press_pattern(4'd12, 1'b0);
    // Longest quiet time holds off the sample across a few ticks
    write_quiet(16'd65535);
    send_beat(djk_pkg::REQ_EDGE, 4'd7, 1'b0);
    repeat (3) send_beat(djk_pkg::REQ_TICK, 4'd7, 1'b0);

    random_phase(0, 0, 16'd1, 40);
    random_phase(84, 0, 16'd3, 40);
    r = $urandom_range(4, 1);
    random_phase(0, 84, 16'(r), 40);
    random_phase(30, 30, 16'd2, 40);

    src_idle_pct = 0;
    drain();

    $display("run: %0d input beats, %0d key events, %0d sampling ticks with key changes",
             sb.beats, sb.events_seen, sb.key_decodes);
    $display("     quiet settings %p across four idle/stall mixes, %0d mismatches",
             quiet_used, sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("[debounced_joystick_key_decoder_unit] OK");
    end else begin
      $display("[debounced_joystick_key_decoder_unit] ERROR");
    end
    $finish;
  end

endmodule
